[rtl/stnl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stnl_pkg
// Shared types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package stnl_pkg;

  // Input kinds carried in tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_WHEELBASE = 3'd0;
  localparam logic [2:0] CFG_GAIN      = 3'd1;
  localparam logic [2:0] CFG_SOFTENING = 3'd2;
  localparam logic [2:0] CFG_LIMIT     = 3'd3;
  localparam logic [2:0] CFG_POINTS    = 3'd4;

  // Angles and gains
  localparam logic signed [17:0] PI_Q12      = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [55:0] GAIN_Q30    = 56'sd652032874;

  // Command from controller to datapath
  typedef struct packed {
    logic capture;
    logic load_write;
    logic cordic_start;
    logic cordic_vec;
    logic ang_head;
    logic front_x;
    logic front_y;
    logic scan_start;
    logic scan_issue;
    logic read_best;
    logic head_setup;
    logic round_sc;
    logic prod;
    logic cte;
    logic num;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cordic_done;
    logic issue_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

  // atan(2^-i) in Q29
  function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      5'd0:  r = 34'sd421657428;
      5'd1:  r = 34'sd248918915;
      5'd2:  r = 34'sd131521918;
      5'd3:  r = 34'sd66762579;
      5'd4:  r = 34'sd33510843;
      5'd5:  r = 34'sd16771755;
      5'd6:  r = 34'sd8387925;
      5'd7:  r = 34'sd4194219;
      5'd8:  r = 34'sd2097141;
      5'd9:  r = 34'sd1048575;
      5'd10: r = 34'sd524288;
      5'd11: r = 34'sd262144;
      5'd12: r = 34'sd131072;
      5'd13: r = 34'sd65536;
      5'd14: r = 34'sd32768;
      5'd15: r = 34'sd16384;
      5'd16: r = 34'sd8192;
      5'd17: r = 34'sd4096;
      5'd18: r = 34'sd2048;
      5'd19: r = 34'sd1024;
      5'd20: r = 34'sd512;
      5'd21: r = 34'sd256;
      5'd22: r = 34'sd128;
      5'd23: r = 34'sd64;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/stanley_path_steering.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stanley_path_steering
// Stanley lateral controller with a path-point store and nearest-point search.
// ----------------------------------------------------------------------------
//
//  channel  direction  width  beat meaning
//  s_*      in         184    load a path point (tuser 0) or query pose (1)
//  m_*      out        24     steering command and nearest point index
//  cfg_*    in         16     register write, index on cfg_addr
//
//  A load beat is written into the store at its accepting edge. A query
//  runs three passes of the shared CORDIC and a scan of N points, N being
//  the number of points searched (128 at the defaults): the scan reads one
//  point a cycle from the single store read port, then the pipeline drains.
//  Reset clears control and restores configuration defaults; the point store is not cleared.
//  A result waits in the output register; a new beat is taken meanwhile,
//  and a query finishing against a stalled output holds until it drains.
//
module stanley_path_steering #(
  parameter int MAX_POINTS   = 128,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic         s_tuser,   // [0] func
  // [6:0] point_index, [38:7] point_x, [70:39] point_y, [85:71] point_heading,
  // [117:86] rear_x, [149:118] rear_y, [164:150] vehicle_yaw, [180:165] speed
  input  wire logic [183:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [23:0]       m_tdata,   // [14:0] steer_angle, [21:15] nearest_index
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_data
);
  import stnl_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic signed [14:0] steer_angle;
  logic [6:0]         nearest_index;

  // Sequencer: accepts beats only between queries
  stnl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  // Store, scan and arithmetic; fields are unpacked straight from tdata
  stnl_datapath #(
    .MAX_POINTS   (MAX_POINTS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .point_index   (s_tdata[6:0]),
    .point_x       (s_tdata[38:7]),
    .point_y       (s_tdata[70:39]),
    .point_heading (s_tdata[85:71]),
    .rear_x        (s_tdata[117:86]),
    .rear_y        (s_tdata[149:118]),
    .vehicle_yaw   (s_tdata[164:150]),
    .speed         (s_tdata[180:165]),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .steer_angle   (steer_angle),
    .nearest_index (nearest_index)
  );

  // Pack result beat, pad to whole bytes
  assign m_tdata = {2'b00, nearest_index, steer_angle};

endmodule
`default_nettype wire

[rtl/stnl_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stnl_cordic
// Shared iterative CORDIC: rotation for sin/cos, vectoring for atan2.
// ----------------------------------------------------------------------------
module stnl_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               vec,
  input  wire logic signed [14:0] ang,
  input  wire logic signed [55:0] vx,
  input  wire logic signed [55:0] vy,
  output logic                    done,
  output logic signed [33:0]      sin_q30,
  output logic signed [33:0]      cos_q30,
  output logic signed [33:0]      z_q29
);
  import stnl_pkg::*;

  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic signed [55:0] x, y, sx, sy;
  logic signed [33:0] z, za, tab;
  logic               neg, busy, mode_vec, dir;
  logic [SW-1:0]      cnt;

  assign za  = {{2{ang[14]}}, ang, 17'b0};
  assign sx  = x >>> cnt;
  assign sy  = y >>> cnt;
  assign tab = atan_q29(5'(cnt));
  // Rotate toward zero residual angle, or toward y = 0 when vectoring
  assign dir = mode_vec ? y[55] : !z[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == SW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= '0;
      mode_vec <= vec;
      if (vec) begin
        neg <= 1'b0;
        if (vx[55]) begin
          z <= vy[55] ? -PI_Q29 : PI_Q29;
          x <= -vx;
          y <= -vy;
        end else begin
          z <= '0;
          x <= vx;
          y <= vy;
        end
      end else begin
        x <= GAIN_Q30;
        y <= '0;
        if (za > HALF_PI_Q29) begin
          z   <= za - PI_Q29;
          neg <= 1'b1;
        end else if (za < -HALF_PI_Q29) begin
          z   <= za + PI_Q29;
          neg <= 1'b1;
        end else begin
          z   <= za;
          neg <= 1'b0;
        end
      end
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (dir) begin
        x <= x - sy;
        y <= y + sx;
        z <= z - tab;
      end else begin
        x <= x + sy;
        y <= y - sx;
        z <= z + tab;
      end
    end
  end

  assign sin_q30 = neg ? -34'(y) : 34'(y);
  assign cos_q30 = neg ? -34'(x) : 34'(x);
  assign z_q29   = z;

endmodule
`default_nettype wire

[rtl/stnl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stnl_datapath
// Point store, config registers, nearest-point scan pipeline, Stanley math.
// ----------------------------------------------------------------------------
module stnl_datapath #(
  parameter int MAX_POINTS   = 128,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire stnl_pkg::cmd_t     cmd,
  output stnl_pkg::sts_t          sts,
  input  wire logic [6:0]         point_index,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [14:0] point_heading,
  input  wire logic signed [31:0] rear_x,
  input  wire logic signed [31:0] rear_y,
  input  wire logic signed [14:0] vehicle_yaw,
  input  wire logic signed [15:0] speed,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_addr,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [14:0]      steer_angle,
  output logic [6:0]              nearest_index
);
  import stnl_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Configuration
  logic [15:0] wheelbase, gain, soften;
  logic [13:0] lim;
  logic [7:0]  piu;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase <= 16'd256;
      gain      <= 16'd256;
      soften    <= 16'd256;
      lim       <= 14'd2144;
      piu       <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WHEELBASE: wheelbase <= cfg_data;
        CFG_GAIN:      gain      <= cfg_data;
        CFG_SOFTENING: soften    <= cfg_data;
        CFG_LIMIT:     lim       <= cfg_data[13:0];
        CFG_POINTS:    piu       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Query capture
  logic signed [31:0] rear_x_r, rear_y_r;
  logic signed [14:0] yaw_r;
  logic signed [15:0] speed_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rear_x_r <= rear_x;
      rear_y_r <= rear_y;
      yaw_r    <= vehicle_yaw;
      speed_r  <= speed;
    end
  end

  // Point store
  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [14:0] mem_h [MAX_POINTS];
  logic signed [31:0] rd_x, rd_y;
  logic signed [14:0] rd_h;
  logic [CW-1:0]      icnt;
  logic [AW-1:0]      best, raddr;

  assign raddr = cmd.read_best ? best : icnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_write && (32'(point_index) < MAX_POINTS)) begin
      mem_x[AW'(point_index)] <= point_x;
      mem_y[AW'(point_index)] <= point_y;
      mem_h[AW'(point_index)] <= point_heading;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue || cmd.read_best) begin
      rd_x <= mem_x[raddr];
      rd_y <= mem_y[raddr];
      rd_h <= mem_h[raddr];
    end
  end

  // Shared CORDIC
  logic signed [33:0] sin_q30, cos_q30, z_q29;
  logic signed [54:0] num;
  logic signed [33:0] den;

  stnl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.cordic_start),
    .vec     (cmd.cordic_vec),
    .ang     (cmd.ang_head ? rd_h : yaw_r),
    .vx      (56'(den)),
    .vy      (56'(num)),
    .done    (sts.cordic_done),
    .sin_q30 (sin_q30),
    .cos_q30 (cos_q30),
    .z_q29   (z_q29)
  );

  // Front axle projection, one axis per cycle
  logic signed [32:0] fx, fy;
  logic signed [50:0] lprod, lrnd;

  assign lprod = $signed({1'b0, wheelbase}) * (cmd.front_y ? sin_q30 : cos_q30);
  assign lrnd  = (lprod + 51'sd2097152) >>> 22;

  always_ff @(posedge clk) begin
    if (cmd.front_x) fx <= 33'(rear_x_r) + 33'(lrnd);
    if (cmd.front_y) fy <= 33'(rear_y_r) + 33'(lrnd);
  end

  // Nearest-point scan: read, diff, partial products, squares, sum, compare
  logic [CW-1:0]      n_eff;
  logic               v_rd, v_df, v_pp, v_sq, v_sm, first;
  logic [AW-1:0]      t_rd, t_df, t_pp, t_sq, t_sm;
  logic signed [33:0] ddx, ddy;
  logic [33:0]        mx, my;
  logic [33:0]        xaa, xab, xbb, yaa, yab, ybb;
  logic [67:0]        sqx, sqy;
  logic [68:0]        dsum, bd;

  assign n_eff = (piu == 8'd0) ? CW'(1) :
                 ((32'(piu) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(piu));
  assign sts.issue_last = (icnt == n_eff - CW'(1));
  assign sts.pipe_empty = !(v_rd || v_df || v_pp || v_sq || v_sm);

  assign ddx = 34'(fx) - 34'(rd_x);
  assign ddy = 34'(fy) - 34'(rd_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd <= 1'b0;
      v_df <= 1'b0;
      v_pp <= 1'b0;
      v_sq <= 1'b0;
      v_sm <= 1'b0;
    end else begin
      v_rd <= cmd.scan_issue;
      v_df <= v_rd;
      v_pp <= v_df;
      v_sq <= v_pp;
      v_sm <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      icnt  <= '0;
      best  <= '0;
      first <= 1'b1;
    end else begin
      if (cmd.scan_issue) icnt <= icnt + CW'(1);
      if (v_sm && (first || dsum < bd)) begin
        bd    <= dsum;
        best  <= t_sm;
        first <= 1'b0;
      end
    end
    t_rd <= icnt[AW-1:0];
    t_df <= t_rd;
    t_pp <= t_df;
    t_sq <= t_pp;
    t_sm <= t_sq;
    mx   <= ddx[33] ? 34'(-ddx) : 34'(ddx);
    my   <= ddy[33] ? 34'(-ddy) : 34'(ddy);
    xaa  <= 34'(mx[33:17]) * 34'(mx[33:17]);
    xab  <= 34'(mx[33:17]) * 34'(mx[16:0]);
    xbb  <= 34'(mx[16:0]) * 34'(mx[16:0]);
    yaa  <= 34'(my[33:17]) * 34'(my[33:17]);
    yab  <= 34'(my[33:17]) * 34'(my[16:0]);
    ybb  <= 34'(my[16:0]) * 34'(my[16:0]);
    sqx  <= (68'(xaa) << 34) + (68'(xab) << 18) + 68'(xbb);
    sqy  <= (68'(yaa) << 34) + (68'(yab) << 18) + 68'(ybb);
    dsum <= 69'(sqx) + 69'(sqy);
  end

  // Cross-track error, heading error, atan2 operands
  logic signed [33:0] dxr, dyr;
  logic signed [17:0] s16, c16;
  logic signed [52:0] p1, p2;
  logic signed [53:0] psum;
  logic signed [37:0] cte;
  logic signed [15:0] hdiff;
  logic signed [16:0] psi;
  logic signed [33:0] s_rnd, c_rnd, z_rnd;
  logic signed [17:0] den_base;
  logic               atan_zero;

  assign hdiff    = 16'(rd_h) - 16'(yaw_r);
  assign s_rnd    = (sin_q30 + 34'sd8192) >>> 14;
  assign c_rnd    = (cos_q30 + 34'sd8192) >>> 14;
  assign psum     = 54'(p1) + 54'(p2);
  assign den_base = $signed({2'b0, soften}) + 18'(speed_r);

  always_ff @(posedge clk) begin
    if (cmd.head_setup) begin
      dxr <= 34'(rd_x) - 34'(fx);
      dyr <= 34'(rd_y) - 34'(fy);
      if (17'(hdiff) > 17'(PI_Q12))       psi <= 17'(hdiff) - 17'(TWO_PI_Q12);
      else if (17'(hdiff) < -17'(PI_Q12)) psi <= 17'(hdiff) + 17'(TWO_PI_Q12);
      else                                psi <= 17'(hdiff);
    end
    if (cmd.round_sc) begin
      s16 <= 18'(s_rnd);
      c16 <= 18'(c_rnd);
    end
    if (cmd.prod) begin
      p1 <= -(53'(dxr) * 53'(s16));
      p2 <= 53'(dyr) * 53'(c16);
    end
    if (cmd.cte) cte <= 38'((psum + 54'sd32768) >>> 16);
    if (cmd.num) begin
      num <= $signed({1'b0, gain}) * cte;
      den <= {den_base, 16'b0};
    end
    if (cmd.cordic_start && cmd.cordic_vec) atan_zero <= (num == '0) && (den == '0);
  end

  // Final sum, clamp, output register
  logic signed [17:0] atan_q12;
  logic signed [18:0] steer, slim, sclamp;

  assign z_rnd    = (z_q29 + 34'sd65536) >>> 17;
  assign atan_q12 = atan_zero ? 18'sd0 : 18'(z_rnd);
  assign steer    = 19'(psi) + 19'(atan_q12);
  assign slim     = $signed({5'b0, lim});
  assign sclamp   = (steer > slim) ? slim : ((steer < -slim) ? -slim : steer);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      steer_angle   <= sclamp[14:0];
      nearest_index <= 7'(best);
    end
  end

endmodule
`default_nettype wire

[rtl/stnl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stnl_ctrl
// Sequencer for load and query beats.
// ----------------------------------------------------------------------------
module stnl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           func,
  input  wire stnl_pkg::sts_t sts,
  output stnl_pkg::cmd_t      cmd,
  output logic                in_ready
);
  import stnl_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_YAW   = 5'd1;
  localparam logic [4:0] ST_YAWW  = 5'd2;
  localparam logic [4:0] ST_FX    = 5'd3;
  localparam logic [4:0] ST_FY    = 5'd4;
  localparam logic [4:0] ST_SCAN  = 5'd5;
  localparam logic [4:0] ST_DRAIN = 5'd6;
  localparam logic [4:0] ST_RD    = 5'd7;
  localparam logic [4:0] ST_HS    = 5'd8;
  localparam logic [4:0] ST_HWAIT = 5'd9;
  localparam logic [4:0] ST_RND   = 5'd10;
  localparam logic [4:0] ST_PROD  = 5'd11;
  localparam logic [4:0] ST_CTE   = 5'd12;
  localparam logic [4:0] ST_NUM   = 5'd13;
  localparam logic [4:0] ST_ATAN  = 5'd14;
  localparam logic [4:0] ST_AWAIT = 5'd15;
  localparam logic [4:0] ST_FIN   = 5'd16;

  logic [4:0] state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_QUERY) begin
            cmd.capture = 1'b1;
            state_next  = ST_YAW;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      ST_YAW: begin
        cmd.cordic_start = 1'b1;
        state_next       = ST_YAWW;
      end
      ST_YAWW: if (sts.cordic_done) state_next = ST_FX;
      ST_FX: begin
        cmd.front_x = 1'b1;
        state_next  = ST_FY;
      end
      ST_FY: begin
        cmd.front_y    = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: if (sts.pipe_empty) state_next = ST_RD;
      ST_RD: begin
        cmd.read_best = 1'b1;
        state_next    = ST_HS;
      end
      ST_HS: begin
        cmd.head_setup   = 1'b1;
        cmd.cordic_start = 1'b1;
        cmd.ang_head     = 1'b1;
        state_next       = ST_HWAIT;
      end
      ST_HWAIT: if (sts.cordic_done) state_next = ST_RND;
      ST_RND: begin
        cmd.round_sc = 1'b1;
        state_next   = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_CTE;
      end
      ST_CTE: begin
        cmd.cte    = 1'b1;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        cmd.num    = 1'b1;
        state_next = ST_ATAN;
      end
      ST_ATAN: begin
        cmd.cordic_start = 1'b1;
        cmd.cordic_vec   = 1'b1;
        state_next       = ST_AWAIT;
      end
      ST_AWAIT: if (sts.cordic_done) state_next = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/stnl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stnl_checker
// Port-level checks on the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module stnl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // Result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Output register empties on reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A query keeps the input side closed while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input accepted during a query");

endmodule

bind stanley_path_steering stnl_checker u_stnl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
